// ===== hw/rtl/escr_pkg.sv =====
// Package for the epoch seconds calendar RTC: request codes, queue entry type,
// calendar helper functions. No dependencies.
`default_nettype none
package escr_pkg;
  localparam logic [31:0] GpsEpoch   = 32'd315964800;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  // reciprocals for exact constant division by multiply and shift
  localparam logic [25:0] DayRecip   = 26'd50903317;  // (t >> 7) / 675, shift 35
  localparam logic [13:0] HourRecip  = 14'd9321;      // (r >> 4) / 225, shift 21
  localparam logic [10:0] MinRecip   = 11'd1093;      // (r >> 2) / 15, shift 14

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_UNIX = 2'd1,
    REQ_GPS  = 2'd2,
    REQ_DATE = 2'd3
  } req_e;

  // front-end to back-end queue entry
  typedef struct packed {
    logic        from_date;  // load from calendar fields
    logic        load;       // load epoch from value
    logic        tick;
    logic        status;
    logic [31:0] value;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cmd_t;

  function automatic logic is_leap(input logic [11:0] y);
    logic c;
    c = (y == 12'd2100) || (y == 12'd2200) || (y == 12'd2300) || (y == 12'd1900);
    return (y[1:0] == 2'b00) && !c;
  endfunction

  function automatic logic [4:0] mdays(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                      r = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/escr_front.sv =====
// Front end: accepts requests, validates date sets, pushes commands to queue.
// Depends on escr_pkg.
`default_nettype none
module escr_front (
  input  logic [1:0]  req_type_i,
  input  logic [31:0] seconds_value_i,
  input  logic [11:0] set_year_i,
  input  logic [3:0]  set_month_i,
  input  logic [4:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [5:0]  set_second_i,
  output escr_pkg::cmd_t cmd_o
);
  import escr_pkg::*;
  logic ok;
  always_comb begin
    ok = (set_year_i >= 12'd1970) && (set_year_i <= 12'd2037)
      && (set_month_i >= 4'd1) && (set_month_i <= 4'd12)
      && (set_day_i >= 5'd1) && (set_day_i <= mdays(set_year_i, set_month_i))
      && (set_hour_i <= 5'd23) && (set_minute_i <= 6'd59) && (set_second_i <= 6'd59);
    cmd_o = '0;
    cmd_o.year = set_year_i;
    cmd_o.month = set_month_i;
    cmd_o.day = set_day_i;
    cmd_o.hour = set_hour_i;
    cmd_o.minute = set_minute_i;
    cmd_o.second = set_second_i;
    cmd_o.value = seconds_value_i;
    unique case (req_e'(req_type_i))
      REQ_TICK: cmd_o.tick = 1'b1;
      REQ_UNIX: cmd_o.load = 1'b1;
      REQ_GPS: begin
        cmd_o.load = 1'b1;
        cmd_o.value = seconds_value_i + GpsEpoch;
      end
      REQ_DATE: begin
        cmd_o.from_date = ok;
        cmd_o.status = !ok;
      end
      default: cmd_o.tick = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/escr_fifo.sv =====
// Two-entry command queue between front and back ends.
// Depends on escr_pkg.
`default_nettype none
module escr_fifo (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  escr_pkg::cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output escr_pkg::cmd_t rd_data_o
);
  import escr_pkg::*;
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !rd |=> cnt_q == 2'd2) else $error("full queue lost entry");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 && !wr |=> !rd_valid_o) else $error("empty queue read");
endmodule
`default_nettype wire

// ===== hw/rtl/escr_back.sv =====
// Back end: holds the counters, applies commands and walks the calendar
// iteratively (date to seconds and seconds to date). Depends on escr_pkg.
`default_nettype none
module escr_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  escr_pkg::cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [134:0] out_data_o
);
  import escr_pkg::*;
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_DYR = 11'b00000000010, S_DMON = 11'b00000000100,
    S_DFIN = 11'b00000001000, S_DIV = 11'b00000010000, S_REM  = 11'b00000100000,
    S_HR   = 11'b00001000000, S_MIN = 11'b00010000000, S_SEC  = 11'b00100000000,
    S_CYR  = 11'b01000000000, S_CMON = 11'b10000000000
  } state_e;
  state_e st_q;
  logic [31:0] epoch_q, up_q, rem_q, t_q;
  logic [15:0] days_q;
  logic [11:0] y_q, sy_q;
  logic [3:0]  m_q, sm_q;
  logic [4:0]  sd_q, sh_q;
  logic [5:0]  smi_q, ss_q;
  logic        stat_q, ov_q;
  logic [4:0]  hr_q;
  logic [5:0]  mn_q;
  logic [8:0]  ydays;
  logic [4:0]  md;
  logic [50:0] dprod;
  logic [26:0] hprod;
  logic [20:0] mprod;
  logic [5:0]  sc;
  logic [31:0] gps, hms;
  assign ydays = is_leap(y_q) ? 9'd366 : 9'd365;
  assign md = mdays(y_q, m_q);
  assign cmd_ready_o = st_q == S_IDLE && !ov_q;
  assign dprod = 51'(t_q[31:7]) * 51'(DayRecip);
  assign hprod = 27'(rem_q[16:4]) * 27'(HourRecip);
  assign mprod = 21'(rem_q[11:2]) * 21'(MinRecip);
  assign sc = 6'(rem_q[11:0] - 12'(mn_q) * 12'd60);
  assign gps = (t_q < GpsEpoch) ? 32'd0 : t_q - GpsEpoch;
  assign hms = 32'(sh_q) * 32'd3600 + 32'(smi_q) * 32'd60 + 32'(ss_q);
  assign out_valid_o = ov_q;
  // status, unix, gps, uptime, year, month, day, hour, minute, second
  assign out_data_o = {sc, mn_q, hr_q, 5'(days_q + 16'd1), m_q, y_q,
                       up_q, gps, t_q, stat_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      epoch_q <= GpsEpoch;
      up_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          stat_q <= cmd_i.status;
          sy_q <= cmd_i.year; sm_q <= cmd_i.month; sd_q <= cmd_i.day;
          sh_q <= cmd_i.hour; smi_q <= cmd_i.minute; ss_q <= cmd_i.second;
          if (cmd_i.from_date) begin
            y_q <= 12'd1970; m_q <= 4'd1;
            days_q <= 16'(cmd_i.day) - 16'd1;
            st_q <= S_DYR;
          end else begin
            if (cmd_i.tick) begin
              epoch_q <= epoch_q + 32'd1;
              up_q <= up_q + 32'd1;
              t_q <= epoch_q + 32'd1;
            end else if (cmd_i.load) begin
              epoch_q <= cmd_i.value;
              t_q <= cmd_i.value;
            end else t_q <= epoch_q;
            st_q <= S_DIV;
          end
        end
        S_DYR: if (y_q == sy_q) st_q <= S_DMON;
          else begin
            days_q <= days_q + 16'(ydays);
            y_q <= y_q + 12'd1;
          end
        S_DMON: if (m_q == sm_q) st_q <= S_DFIN;
          else begin
            days_q <= days_q + 16'(md);
            m_q <= m_q + 4'd1;
          end
        S_DFIN: begin
          epoch_q <= 32'(days_q) * 32'(SecsPerDay) + hms;
          t_q <= 32'(days_q) * 32'(SecsPerDay) + hms;
          st_q <= S_DIV;
        end
        // seconds to days, then time of day, one product per cycle
        S_DIV: begin
          days_q <= dprod[50:35];
          st_q <= S_REM;
        end
        S_REM: begin
          rem_q <= t_q - 32'(days_q) * 32'(SecsPerDay);
          st_q <= S_HR;
        end
        S_HR: begin
          hr_q <= hprod[25:21];
          st_q <= S_MIN;
        end
        S_MIN: begin
          rem_q <= rem_q - 32'(hr_q) * 32'd3600;
          st_q <= S_SEC;
        end
        S_SEC: begin
          mn_q <= mprod[19:14];
          y_q <= 12'd1970; m_q <= 4'd1;
          st_q <= S_CYR;
        end
        S_CYR: if (days_q >= 16'(ydays)) begin
            days_q <= days_q - 16'(ydays);
            y_q <= y_q + 12'd1;
          end else st_q <= S_CMON;
        S_CMON: if (m_q < 4'd12 && days_q >= 16'(md)) begin
            days_q <= days_q - 16'(md);
            m_q <= m_q + 4'd1;
          end else begin
            ov_q <= 1'b1;
            st_q <= S_IDLE;
          end
        default: st_q <= S_IDLE;
      endcase
    end
  end
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> $stable(t_q)) else $error("result changed while held");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !cmd_ready_o) else $error("accepted while busy");
  a_mon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CMON |-> m_q >= 4'd1 && m_q <= 4'd12) else $error("month out of range");
endmodule
`default_nettype wire

// ===== hw/rtl/epoch_seconds_calendar_rtc.sv =====
// Epoch seconds calendar RTC: Unix second counter, uptime counter and
// calendar conversion. Uses escr_pkg, escr_front, escr_fifo, escr_back.
//
// Input stream s_axis: one request per word; tuser is the request kind
// (0 tick, 1 set Unix, 2 set GPS, 3 set date), tdata the value and date
// fields. Output stream m_axis: one result word per request with status,
// Unix, GPS and uptime seconds and the broken-down date and time.
// A request is classified in the front end and queued (two deep); the back
// end applies it, splits the seconds into days, hours, minutes and seconds
// and walks the calendar a year or a month per cycle; a date set first
// turns the date into seconds by a like walk from 1970.
// One request is converted at a time. Reset loads the count with the GPS
// epoch and clears uptime. A stalled output holds its word and the back end
// waits; the queue keeps accepting until full.
`default_nettype none
module epoch_seconds_calendar_rtc (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seconds_value, set_year, set_month, set_day, set_hour, set_minute,
  // set_second (+2 pad bits)
  input  logic [71:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, unix_seconds, gps_seconds, uptime_seconds, cal_year, cal_month,
  // cal_day, cal_hour, cal_minute, cal_second (+1 pad bit)
  output logic [135:0] m_axis_tdata
);
  import escr_pkg::*;
  cmd_t fc, qc;
  logic qv, qr;
  logic [134:0] od;
  escr_front u_front (
    .req_type_i(s_axis_tuser), .seconds_value_i(s_axis_tdata[31:0]),
    .set_year_i(s_axis_tdata[43:32]), .set_month_i(s_axis_tdata[47:44]),
    .set_day_i(s_axis_tdata[52:48]), .set_hour_i(s_axis_tdata[57:53]),
    .set_minute_i(s_axis_tdata[63:58]), .set_second_i(s_axis_tdata[69:64]),
    .cmd_o(fc));
  escr_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready),
    .wr_data_i(fc), .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qc));
  escr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qc),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(od));
  assign m_axis_tdata = {1'b0, od};
endmodule
`default_nettype wire
